[hdl/ptom_pkg.sv]
// Shared types and constants for the price-time order matcher.
package ptom_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned QTY_W   = 32;
    localparam int unsigned AMT_W   = 37;
    localparam int unsigned TS_W    = 48;
    localparam int unsigned PRICE_W = 16;
    localparam int unsigned KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_LIMIT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MARKET = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

    // One result beat before packing
    typedef struct packed {
        logic              is_trade;
        logic              last;
        logic [ID_W-1:0]   maker_ref;
        logic [ID_W-1:0]   taker_ref;
        logic [15:0]       trade_price;
        logic [AMT_W-1:0]  amount;
        logic [TS_W-1:0]   timestamp;
        logic              ok;
        logic [15:0]       top_bid;
        logic              top_bid_vld;
        logic [15:0]       top_ask;
        logic              top_ask_vld;
    } result_t;

endpackage

[hdl/ptom_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module ptom_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/price_time_order_matcher_unit.sv]
// Top level of the price-time order matcher: sequencer over the slot memory.
//
//  channel  | dir | tdata fields (low bit first)                | tuser / tlast
//  s_axis   | in  | order_id, side, price, quantity, pad        | tuser = kind
//  m_axis   | out | maker_ref, taker_ref, trade_price, amount,  | tuser = is_trade,
//           |     | timestamp, ok, top_bid, top_bid_vld,        | tlast = last
//           |     | top_ask, top_ask_vld                        |
//
// A pass reads every slot once through the registered read port of the slot memory.
// Limit/market: one match pass per fill plus a last empty one unless fully filled;
// a limit remainder adds a free-slot pass. Cancel, modify and query add one lookup
// pass; every item ends with a best bid/ask pass. Valid bits and the event clock
// reset to 0; a held output beat stalls the fill, final and wait steps, not the scan.
module price_time_order_matcher_unit #(
    parameter int unsigned POOL_SLOTS = 32,
    parameter int unsigned PRICE_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,  // order_id[31:0] side[32] price[48:33] quantity[80:49]
    input  logic [2:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,  // maker_ref,taker_ref,trade_price,amount,timestamp,ok,
                                        // top_bid,top_bid_vld,top_ask,top_ask_vld
    output logic         m_axis_tuser,  // is_trade
    output logic         m_axis_tlast   // last
);

    localparam int unsigned AW = $clog2(POOL_SLOTS);
    localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
    localparam int unsigned SW = ptom_pkg::ID_W + 1 + PRICE_BITS + ptom_pkg::QTY_W
                                 + ptom_pkg::TS_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_FILL  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_BOOK  = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_MATCH = 3'd0,
        PH_FREE  = 3'd1,
        PH_FIND  = 3'd2,
        PH_QUERY = 3'd3,
        PH_BOOK  = 3'd4
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    // Input item registers
    logic [2:0]                   kind_reg;
    logic [ptom_pkg::ID_W-1:0]    id_reg;
    logic                         side_reg;
    logic [PRICE_BITS-1:0]        price_reg;
    logic [ptom_pkg::QTY_W-1:0]   qty_reg;
    logic [ptom_pkg::QTY_W-1:0]   rem_reg;
    logic [ptom_pkg::TS_W-1:0]    clock_reg;

    logic [POOL_SLOTS-1:0]        valid_reg;

    // Scan state
    logic [CW-1:0]                cnt_reg;
    logic                         rd_vld_reg;
    logic [AW-1:0]                rd_idx_reg;
    logic                         hit_reg;
    logic [AW-1:0]                hit_idx_reg;
    logic [SW-1:0]                hit_dat_reg;
    logic [ptom_pkg::AMT_W-1:0]   tot_reg;
    logic                         bid_v_reg, ask_v_reg;
    logic [PRICE_BITS-1:0]        bid_reg, ask_reg;
    logic                         ok_reg;
    logic [ptom_pkg::TS_W-1:0]    ts_reg;

    ptom_pkg::result_t            out_reg;
    logic                         out_v_reg;

    // Slot memory
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [SW-1:0]                wdata, rdata;
    logic [AW-1:0]                raddr;

    ptom_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Slot fields from the read data
    logic [ptom_pkg::ID_W-1:0]  r_id;
    logic                       r_side;
    logic [PRICE_BITS-1:0]      r_price;
    logic [ptom_pkg::QTY_W-1:0] r_amt;
    logic [ptom_pkg::TS_W-1:0]  r_ts;
    assign {r_ts, r_amt, r_price, r_side, r_id} = rdata;

    logic [PRICE_BITS-1:0]      h_price;
    logic [ptom_pkg::QTY_W-1:0] h_amt;
    logic [ptom_pkg::TS_W-1:0]  h_ts;
    logic [ptom_pkg::ID_W-1:0]  h_id;
    logic                       h_side;
    assign {h_ts, h_amt, h_price, h_side, h_id} = hit_dat_reg;

    logic [ptom_pkg::QTY_W-1:0] fill;
    assign fill = (h_amt < rem_reg) ? h_amt : rem_reg;

    logic out_free;
    assign out_free = !out_v_reg || m_axis_tready;

    // A trade or final beat enters the output register this cycle
    logic out_load;
    assign out_load = out_free && (state_reg == ST_FILL || state_reg == ST_FINAL);

    assign raddr = cnt_reg[AW-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Per-slot candidate test during a pass
    logic cand, better, rv;
    logic [ptom_pkg::AMT_W-1:0] tsum;
    always_comb
    begin
        rv = rd_vld_reg && valid_reg[rd_idx_reg];
        cand = 1'b0;
        better = 1'b0;
        unique case (phase_reg)
            PH_MATCH:
            begin
                cand = rv && (r_side != side_reg) &&
                       (kind_reg != ptom_pkg::KIND_LIMIT ||
                        (side_reg ? r_price >= price_reg : r_price <= price_reg));
                if (!hit_reg)
                    better = 1'b1;
                else if (r_price != h_price)
                    better = side_reg ? (r_price > h_price) : (r_price < h_price);
                else
                    better = r_ts < h_ts;
            end
            PH_FREE:
            begin
                cand = rd_vld_reg && !valid_reg[rd_idx_reg];
                better = !hit_reg;
            end
            PH_FIND:
            begin
                cand = rv && r_id == id_reg;
                better = !hit_reg;
            end
            default:
            begin
                cand = rv && r_side == side_reg && r_price == price_reg;
                better = 1'b0;
            end
        endcase
        tsum = tot_reg + {5'd0, r_amt};
        if (tsum < tot_reg)
            tsum = ptom_pkg::AMT_MAX;
    end

    // Memory write port
    always_comb
    begin
        we = 1'b0;
        waddr = hit_idx_reg;
        wdata = hit_dat_reg;
        if (state_reg == ST_FILL && out_free)
        begin
            we = 1'b1;
            wdata = {h_ts, h_amt - fill, h_price, h_side, h_id};
        end
        else if (state_reg == ST_WRITE)
        begin
            we = (phase_reg == PH_FREE) ? hit_reg :
                 (hit_reg && kind_reg == ptom_pkg::KIND_MODIFY &&
                  qty_reg != '0 && qty_reg < h_amt);
            wdata = (phase_reg == PH_FREE) ?
                    {clock_reg, rem_reg, price_reg, side_reg, id_reg} :
                    {h_ts, qty_reg, h_price, h_side, h_id};
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_MATCH;
            valid_reg  <= '0;
            clock_reg  <= '0;
            out_v_reg  <= 1'b0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            // Output register: a new beat replaces the one taken this cycle
            if (out_load)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg  <= s_axis_tuser;
                        id_reg    <= s_axis_tdata[31:0];
                        side_reg  <= s_axis_tdata[32];
                        price_reg <= PRICE_BITS'(s_axis_tdata[48:33]);
                        qty_reg   <= s_axis_tdata[80:49];
                        rem_reg   <= s_axis_tdata[80:49];
                        ok_reg    <= (s_axis_tuser == ptom_pkg::KIND_LIMIT ||
                                      s_axis_tuser == ptom_pkg::KIND_MARKET);
                        tot_reg   <= '0;
                        ts_reg    <= '0;
                        cnt_reg   <= '0;
                        hit_reg   <= 1'b0;
                        rd_vld_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                        unique case (s_axis_tuser)
                            ptom_pkg::KIND_LIMIT, ptom_pkg::KIND_MARKET:
                                phase_reg <= PH_MATCH;
                            ptom_pkg::KIND_CANCEL, ptom_pkg::KIND_MODIFY:
                                phase_reg <= PH_FIND;
                            ptom_pkg::KIND_QUERY: phase_reg <= PH_QUERY;
                            default: phase_reg <= PH_BOOK;
                        endcase
                        bid_v_reg <= 1'b0;
                        ask_v_reg <= 1'b0;
                        bid_reg   <= '0;
                        ask_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    // Skip a match pass once nothing is left to fill
                    if (phase_reg == PH_MATCH && rem_reg == '0)
                    begin
                        phase_reg <= PH_BOOK;
                        cnt_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        hit_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_vld_reg <= (cnt_reg < CW'(POOL_SLOTS));
                        rd_idx_reg <= cnt_reg[AW-1:0];
                        if (cnt_reg < CW'(POOL_SLOTS))
                            cnt_reg <= cnt_reg + 1'b1;
                        if (phase_reg == PH_BOOK)
                        begin
                            if (rv && !r_side && (!bid_v_reg || r_price > bid_reg))
                            begin
                                bid_reg <= r_price;
                                bid_v_reg <= 1'b1;
                            end
                            if (rv && r_side && (!ask_v_reg || r_price < ask_reg))
                            begin
                                ask_reg <= r_price;
                                ask_v_reg <= 1'b1;
                            end
                        end
                        else if (phase_reg == PH_QUERY)
                        begin
                            if (cand)
                            begin
                                ok_reg  <= 1'b1;
                                tot_reg <= tsum;
                            end
                        end
                        else if (cand && better)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                            hit_dat_reg <= rdata;
                        end
                        // End of pass
                        if (cnt_reg == CW'(POOL_SLOTS) && !rd_vld_reg)
                        begin
                            cnt_reg <= '0;
                            unique case (phase_reg)
                                PH_MATCH:
                                begin
                                    if (hit_reg)
                                        state_reg <= ST_FILL;
                                    else
                                    begin
                                        phase_reg <= (kind_reg == ptom_pkg::KIND_LIMIT)
                                                     ? PH_FREE : PH_BOOK;
                                        hit_reg <= 1'b0;
                                    end
                                end
                                PH_FREE, PH_FIND: state_reg <= ST_WRITE;
                                PH_QUERY:
                                begin
                                    phase_reg <= PH_BOOK;
                                    hit_reg <= 1'b0;
                                end
                                default: state_reg <= ST_FINAL;
                            endcase
                        end
                    end
                end
                ST_FILL:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{is_trade: 1'b1, last: 1'b0, maker_ref: h_id,
                                     taker_ref: id_reg, trade_price: 16'(h_price),
                                     amount: 37'(fill), timestamp: clock_reg,
                                     default: '0};
                        clock_reg <= clock_reg + 1'b1;
                        rem_reg <= rem_reg - fill;
                        if (fill == h_amt)
                            valid_reg[hit_idx_reg] <= 1'b0;
                        hit_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_WRITE:
                begin
                    if (phase_reg == PH_FREE)
                    begin
                        if (hit_reg)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b1;
                            ts_reg <= clock_reg;
                            clock_reg <= clock_reg + 1'b1;
                        end
                        else
                            ok_reg <= 1'b0;
                    end
                    else if (hit_reg)
                    begin
                        if (kind_reg == ptom_pkg::KIND_CANCEL)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            ok_reg <= 1'b1;
                        end
                        else if (qty_reg != '0 && qty_reg < h_amt)
                            ok_reg <= 1'b1;
                    end
                    phase_reg <= PH_BOOK;
                    hit_reg <= 1'b0;
                    state_reg <= ST_BOOK;
                end
                ST_BOOK: state_reg <= ST_SCAN;
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        out_reg.is_trade <= 1'b0;
                        out_reg.last <= 1'b1;
                        out_reg.maker_ref <= '0;
                        out_reg.taker_ref <= id_reg;
                        out_reg.trade_price <= '0;
                        unique case (kind_reg)
                            ptom_pkg::KIND_LIMIT:  out_reg.amount <= 37'(rem_reg);
                            ptom_pkg::KIND_MARKET: out_reg.amount <= 37'(qty_reg - rem_reg);
                            ptom_pkg::KIND_QUERY:  out_reg.amount <= tot_reg;
                            default:               out_reg.amount <= '0;
                        endcase
                        out_reg.timestamp <= ts_reg;
                        out_reg.ok <= ok_reg;
                        out_reg.top_bid <= 16'(bid_reg);
                        out_reg.top_bid_vld <= bid_v_reg;
                        out_reg.top_ask <= 16'(ask_reg);
                        out_reg.top_ask_vld <= ask_v_reg;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: if (out_free) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_reg.is_trade;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {out_reg.top_ask_vld, out_reg.top_ask,
                            out_reg.top_bid_vld, out_reg.top_bid, out_reg.ok,
                            out_reg.timestamp, out_reg.amount, out_reg.trade_price,
                            out_reg.taker_ref, out_reg.maker_ref};

endmodule
